FILE: src/scatr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scatr_pkg - shared types and constants of the ATR parser
// Payload structures, parser phases, status codes and byte limits.
// ----------------------------------------------------------------------------
package scatr_pkg;

    // Longest ATR accepted, TS included
    localparam int unsigned MAX_ATR_BYTES = 33;
    localparam int unsigned CNT_W         = 6;
    localparam logic [CNT_W-1:0] MAX_ATR_LEN = CNT_W'(MAX_ATR_BYTES);

    localparam logic [7:0] TS_DIRECT = 8'h3B;
    localparam logic [4:0] LEVEL_MAX = 5'd31;

    typedef enum logic [2:0] {
        PH_TS    = 3'd0,
        PH_T0    = 3'd1,
        PH_IFACE = 3'd2,
        PH_HIST  = 3'd3,
        PH_TCK   = 3'd4,
        PH_DONE  = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        ST_BUSY    = 2'd0,
        ST_OK      = 2'd1,
        ST_INVALID = 2'd2,
        ST_COMM    = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       rx_error;
        logic       start_of_atr;
    } t_atr_in;

    typedef struct packed {
        logic [1:0]       status;
        logic [CNT_W-1:0] atr_length;
        logic [3:0]       historical_count;
        logic [3:0]       present_mask;
        logic [3:0]       f_index;
        logic [3:0]       d_index;
        logic             ta2_can_change_mode;
        logic             ta2_implicit_fd;
        logic [3:0]       ta2_protocol;
        logic [7:0]       extra_guard_time;
        logic [7:0]       waiting_integer;
        logic [15:0]      protocols_mask;
    } t_atr_out;

endpackage
`default_nettype wire

FILE: src/scatr_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scatr_if - valid/ready channels of the ATR parser
// One channel for received ATR bytes, one for parse results.
// ----------------------------------------------------------------------------
interface scatr_in_if;
    logic              valid;
    logic              ready;
    scatr_pkg::t_atr_in data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface scatr_out_if;
    logic               valid;
    logic               ready;
    scatr_pkg::t_atr_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/smart_card_atr_parser_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smart_card_atr_parser_core - ISO 7816-3 style Answer-To-Reset parser
// Walks TS, T0, the TA/TB/TC/TD levels, historical bytes and TCK one byte
// per transfer and returns one status/field result per byte.
// ----------------------------------------------------------------------------
//  Channel   Dir  Payload                                   Transfer when
//  i_atr     in   rx_byte, rx_error, start_of_atr           valid & ready
//  o_res     out  status, lengths, TA1/TA2/TC1/TC2, protos  valid & ready
//
//  The parser state and the result register update at
//  the same edge as the input transfer; the result shows the cycle after.
//  A byte is taken every cycle while the result register is empty or being
//  drained, so back-to-back transfers run at full rate.
//  When o_res stalls with a result waiting, i_atr.ready drops and all state
//  holds. Synchronous active-low reset clears the parser and the result valid
//  flag, not the result payload; there is no memory and so no clearing pass.
// ----------------------------------------------------------------------------
module smart_card_atr_parser_core (
    input  wire               i_clk,
    input  wire               i_rst_n,
    scatr_in_if.sink          i_atr,
    scatr_out_if.source       o_res
);

    // ------------------------------------------------------------------
    // Parser state
    // ------------------------------------------------------------------
    scatr_pkg::t_phase              r_phase,    n_phase;
    logic [3:0]                     r_pending,  n_pending;
    logic [4:0]                     r_level,    n_level;
    logic [scatr_pkg::CNT_W-1:0]    r_count,    n_count;
    logic [3:0]                     r_hist_left, n_hist_left;
    logic [7:0]                     r_xor,      n_xor;
    logic                           r_tck_need, n_tck_need;
    scatr_pkg::t_status             r_final,    n_final;

    // Parsed fields
    logic [3:0]  r_hist_cnt, n_hist_cnt;
    logic [3:0]  r_present,  n_present;
    logic [7:0]  r_ta1,      n_ta1;
    logic [7:0]  r_ta2,      n_ta2;
    logic [7:0]  r_tc1,      n_tc1;
    logic [7:0]  r_tc2,      n_tc2;
    logic [15:0] r_protos,   n_protos;

    // Result register
    logic                 r_out_valid;
    scatr_pkg::t_atr_out  r_res, n_res;

    logic       acc;
    logic [7:0] b;
    logic [3:0] td_proto;

    // Take a byte whenever the result register is free or is being drained
    assign i_atr.ready = !r_out_valid || o_res.ready;
    assign acc         = i_atr.valid && i_atr.ready;
    assign b           = i_atr.data.rx_byte;
    assign td_proto    = b[3:0];

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_res;

    // ------------------------------------------------------------------
    // Next state: start mark clears everything first, then one byte step
    // ------------------------------------------------------------------
    always_comb begin
        if (i_atr.data.start_of_atr) begin
            n_phase     = scatr_pkg::PH_TS;
            n_pending   = '0;
            n_level     = '0;
            n_count     = '0;
            n_hist_left = '0;
            n_xor       = '0;
            n_tck_need  = 1'b0;
            n_final     = scatr_pkg::ST_BUSY;
            n_hist_cnt  = '0;
            n_present   = '0;
            n_ta1       = '0;
            n_ta2       = '0;
            n_tc1       = '0;
            n_tc2       = '0;
            n_protos    = '0;
        end else begin
            n_phase     = r_phase;
            n_pending   = r_pending;
            n_level     = r_level;
            n_count     = r_count;
            n_hist_left = r_hist_left;
            n_xor       = r_xor;
            n_tck_need  = r_tck_need;
            n_final     = r_final;
            n_hist_cnt  = r_hist_cnt;
            n_present   = r_present;
            n_ta1       = r_ta1;
            n_ta2       = r_ta2;
            n_tc1       = r_tc1;
            n_tc2       = r_tc2;
            n_protos    = r_protos;
        end

        if (n_phase != scatr_pkg::PH_DONE) begin
            if (i_atr.data.rx_error) begin
                // Reception failed: end the ATR whatever the phase
                n_final = scatr_pkg::ST_COMM;
                n_phase = scatr_pkg::PH_DONE;
            end else if (n_phase == scatr_pkg::PH_TS) begin
                n_count = scatr_pkg::CNT_W'(1);
                if (b != scatr_pkg::TS_DIRECT) begin
                    n_final = scatr_pkg::ST_INVALID;
                    n_phase = scatr_pkg::PH_DONE;
                end else begin
                    n_phase = scatr_pkg::PH_T0;
                end
            end else if (n_count >= scatr_pkg::MAX_ATR_LEN) begin
                // Over length: drop the byte and fail
                n_final = scatr_pkg::ST_INVALID;
                n_phase = scatr_pkg::PH_DONE;
            end else begin
                n_count = n_count + scatr_pkg::CNT_W'(1);
                n_xor   = n_xor ^ b;
                case (n_phase)
                    scatr_pkg::PH_T0: begin
                        n_hist_left = b[3:0];
                        n_hist_cnt  = b[3:0];
                        n_pending   = b[7:4];
                        n_phase     = scatr_pkg::PH_IFACE;
                    end
                    scatr_pkg::PH_IFACE: begin
                        if (n_pending[0]) begin
                            n_pending = n_pending & 4'b1110;
                            if (n_level == 5'd0) begin
                                n_ta1        = b;
                                n_present[0] = 1'b1;
                            end else if (n_level == 5'd1) begin
                                n_ta2        = b;
                                n_present[1] = 1'b1;
                            end
                        end else if (n_pending[1]) begin
                            // TB carries nothing reported
                            n_pending = n_pending & 4'b1100;
                        end else if (n_pending[2]) begin
                            n_pending = n_pending & 4'b1000;
                            if (n_level == 5'd0) begin
                                n_tc1        = b;
                                n_present[2] = 1'b1;
                            end else if (n_level == 5'd1) begin
                                n_tc2        = b;
                                n_present[3] = 1'b1;
                            end
                        end else begin
                            // TD: record the protocol, open the next level
                            n_protos = n_protos | (16'd1 << td_proto);
                            if (td_proto != 4'd0) begin
                                n_tck_need = 1'b1;
                            end
                            n_pending = b[7:4];
                            if (n_level < scatr_pkg::LEVEL_MAX) begin
                                n_level = n_level + 5'd1;
                            end
                        end
                    end
                    scatr_pkg::PH_HIST: begin
                        n_hist_left = n_hist_left - 4'd1;
                        if (n_hist_left == 4'd0) begin
                            if (n_tck_need) begin
                                n_phase = scatr_pkg::PH_TCK;
                            end else begin
                                n_final = scatr_pkg::ST_OK;
                                n_phase = scatr_pkg::PH_DONE;
                            end
                        end
                    end
                    default: begin
                        // TCK: the running XOR now includes it
                        n_final = (n_xor == 8'd0) ? scatr_pkg::ST_OK
                                                  : scatr_pkg::ST_INVALID;
                        n_phase = scatr_pkg::PH_DONE;
                    end
                endcase

                // Interface bytes exhausted: advance to history, TCK or done
                if (n_phase == scatr_pkg::PH_IFACE && n_pending == 4'd0) begin
                    if (n_hist_left != 4'd0) begin
                        n_phase = scatr_pkg::PH_HIST;
                    end else if (n_tck_need) begin
                        n_phase = scatr_pkg::PH_TCK;
                    end else begin
                        n_final = scatr_pkg::ST_OK;
                        n_phase = scatr_pkg::PH_DONE;
                    end
                end
            end
        end

        // Result seen from the updated state
        n_res.status              = (n_phase == scatr_pkg::PH_DONE) ? n_final
                                                                    : scatr_pkg::ST_BUSY;
        n_res.atr_length          = n_count;
        n_res.historical_count    = n_hist_cnt;
        n_res.present_mask        = n_present;
        n_res.f_index             = n_ta1[7:4];
        n_res.d_index             = n_ta1[3:0];
        n_res.ta2_can_change_mode = n_present[1] && !n_ta2[7];
        n_res.ta2_implicit_fd     = n_ta2[4];
        n_res.ta2_protocol        = n_ta2[3:0];
        n_res.extra_guard_time    = n_tc1;
        n_res.waiting_integer     = n_tc2;
        n_res.protocols_mask      = n_protos;
    end

    // ------------------------------------------------------------------
    // Registers: advance only on an input transfer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= scatr_pkg::PH_TS;
            r_pending   <= '0;
            r_level     <= '0;
            r_count     <= '0;
            r_hist_left <= '0;
            r_xor       <= '0;
            r_tck_need  <= 1'b0;
            r_final     <= scatr_pkg::ST_BUSY;
            r_hist_cnt  <= '0;
            r_present   <= '0;
            r_ta1       <= '0;
            r_ta2       <= '0;
            r_tc1       <= '0;
            r_tc2       <= '0;
            r_protos    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_phase     <= n_phase;
                r_pending   <= n_pending;
                r_level     <= n_level;
                r_count     <= n_count;
                r_hist_left <= n_hist_left;
                r_xor       <= n_xor;
                r_tck_need  <= n_tck_need;
                r_final     <= n_final;
                r_hist_cnt  <= n_hist_cnt;
                r_present   <= n_present;
                r_ta1       <= n_ta1;
                r_ta2       <= n_ta2;
                r_tc1       <= n_tc1;
                r_tc2       <= n_tc2;
                r_protos    <= n_protos;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload: hold while stalled, load on transfer
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_res <= n_res;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_status_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.status != scatr_pkg::ST_BUSY)
            |-> (r_phase == scatr_pkg::PH_DONE))
        else $error("final status shown before the ATR ended");

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= scatr_pkg::MAX_ATR_LEN)
        else $error("byte count beyond the ATR limit");

    a_done_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !i_atr.data.start_of_atr && r_phase == scatr_pkg::PH_DONE)
            |=> ($stable(r_count) && $stable(r_protos) && $stable(r_final)))
        else $error("parser state moved after the ATR ended");

    a_tck_needs_td: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == scatr_pkg::PH_TCK) |-> r_tck_need)
        else $error("TCK expected without a non-zero TD protocol");

endmodule
`default_nettype wire

FILE: sim/smart_card_atr_parser_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smart_card_atr_parser_checker - result predictor and comparator
// Watches both channels of the ATR parser, keeps its own copy of the parse
// state, predicts one result per input transfer and compares in order.
// ----------------------------------------------------------------------------
module smart_card_atr_parser_checker (
    input  wire  i_clk,
    input  wire  i_rst_n,
    scatr_in_if  i_atr,
    scatr_out_if i_res,
    output int   o_fail_count,
    output int   o_pending
);

    // Shadow parse state
    scatr_pkg::t_phase  parse_phase;
    logic [3:0]         pend_presence;
    logic [4:0]         level_num;
    logic [5:0]         byte_num;
    logic [3:0]         hist_left;
    logic [7:0]         xor_sum;
    logic               tck_due;
    logic [3:0]         hist_count;
    logic [3:0]         seen_mask;
    logic [7:0]         ta1_byte;
    logic [7:0]         ta2_byte;
    logic [7:0]         tc1_byte;
    logic [7:0]         tc2_byte;
    logic [15:0]        proto_bits;
    scatr_pkg::t_status end_status;

    scatr_pkg::t_atr_out parse_results_due[$];
    int                  mismatches;

    task automatic clear_parser();
        parse_phase   = scatr_pkg::PH_TS;
        pend_presence = '0;
        level_num     = '0;
        byte_num      = '0;
        hist_left     = '0;
        xor_sum       = '0;
        tck_due       = 1'b0;
        hist_count    = '0;
        seen_mask     = '0;
        ta1_byte      = '0;
        ta2_byte      = '0;
        tc1_byte      = '0;
        tc2_byte      = '0;
        proto_bits    = '0;
        end_status    = scatr_pkg::ST_BUSY;
    endtask

    task automatic close_atr(input scatr_pkg::t_status st);
        end_status  = st;
        parse_phase = scatr_pkg::PH_DONE;
    endtask

    task automatic leave_interface();
        if (hist_left != 4'd0)
            parse_phase = scatr_pkg::PH_HIST;
        else if (tck_due)
            parse_phase = scatr_pkg::PH_TCK;
        else
            close_atr(scatr_pkg::ST_OK);
    endtask

    // TA/TB/TC/TD of the current level; only TA and TC of levels one and two are kept
    task automatic take_interface_byte(input logic [7:0] b);
        if (pend_presence[0]) begin
            pend_presence[0] = 1'b0;
            if (level_num == 5'd0) begin
                ta1_byte     = b;
                seen_mask[0] = 1'b1;
            end else if (level_num == 5'd1) begin
                ta2_byte     = b;
                seen_mask[1] = 1'b1;
            end
        end else if (pend_presence[1]) begin
            pend_presence[1] = 1'b0;
        end else if (pend_presence[2]) begin
            pend_presence[2] = 1'b0;
            if (level_num == 5'd0) begin
                tc1_byte     = b;
                seen_mask[2] = 1'b1;
            end else if (level_num == 5'd1) begin
                tc2_byte     = b;
                seen_mask[3] = 1'b1;
            end
        end else begin
            proto_bits[b[3:0]] = 1'b1;
            if (b[3:0] != 4'd0)
                tck_due = 1'b1;
            pend_presence = b[7:4];
            if (level_num != scatr_pkg::LEVEL_MAX)
                level_num++;
        end
        if (pend_presence == 4'd0)
            leave_interface();
    endtask

    task automatic parse_atr_byte(input scatr_pkg::t_atr_in it,
                                  output scatr_pkg::t_atr_out r);
        logic [7:0] b;
        b = it.rx_byte;
        if (it.start_of_atr)
            clear_parser();
        if (parse_phase != scatr_pkg::PH_DONE) begin
            if (it.rx_error) begin
                close_atr(scatr_pkg::ST_COMM);
            end else if (parse_phase == scatr_pkg::PH_TS) begin
                byte_num = 6'd1;
                if (b != scatr_pkg::TS_DIRECT)
                    close_atr(scatr_pkg::ST_INVALID);
                else
                    parse_phase = scatr_pkg::PH_T0;
            end else if (byte_num >= scatr_pkg::MAX_ATR_LEN) begin
                // a byte beyond the limit ends the ATR and is not counted
                close_atr(scatr_pkg::ST_INVALID);
            end else begin
                byte_num++;
                xor_sum ^= b;
                case (parse_phase)
                    scatr_pkg::PH_T0: begin
                        hist_left     = b[3:0];
                        hist_count    = b[3:0];
                        pend_presence = b[7:4];
                        parse_phase   = scatr_pkg::PH_IFACE;
                        if (pend_presence == 4'd0)
                            leave_interface();
                    end
                    scatr_pkg::PH_IFACE: take_interface_byte(b);
                    scatr_pkg::PH_HIST: begin
                        hist_left--;
                        if (hist_left == 4'd0) begin
                            if (tck_due)
                                parse_phase = scatr_pkg::PH_TCK;
                            else
                                close_atr(scatr_pkg::ST_OK);
                        end
                    end
                    default: begin
                        if (xor_sum == 8'h00)
                            close_atr(scatr_pkg::ST_OK);
                        else
                            close_atr(scatr_pkg::ST_INVALID);
                    end
                endcase
            end
        end

        r.status              = (parse_phase == scatr_pkg::PH_DONE) ? end_status
                                                                    : scatr_pkg::ST_BUSY;
        r.atr_length          = byte_num;
        r.historical_count    = hist_count;
        r.present_mask        = seen_mask;
        r.f_index             = ta1_byte[7:4];
        r.d_index             = ta1_byte[3:0];
        r.ta2_can_change_mode = seen_mask[1] & ~ta2_byte[7];
        r.ta2_implicit_fd     = ta2_byte[4];
        r.ta2_protocol        = ta2_byte[3:0];
        r.extra_guard_time    = tc1_byte;
        r.waiting_integer     = tc2_byte;
        r.protocols_mask      = proto_bits;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        scatr_pkg::t_atr_out want;
        scatr_pkg::t_atr_out got;
        if (!i_rst_n) begin
            clear_parser();
            parse_results_due.delete();
            mismatches = 0;
        end else begin
            // drain first: a result never belongs to this edge's input
            if (i_res.valid && i_res.ready) begin
                got = i_res.data;
                if (parse_results_due.size() == 0) begin
                    $error("result transfer with nothing expected");
                    mismatches++;
                end else begin
                    want = parse_results_due.pop_front();
                    check_field("status", 16'(want.status), 16'(got.status));
                    check_field("atr_length", 16'(want.atr_length), 16'(got.atr_length));
                    check_field("historical_count", 16'(want.historical_count),
                                16'(got.historical_count));
                    check_field("present_mask", 16'(want.present_mask),
                                16'(got.present_mask));
                    check_field("f_index", 16'(want.f_index), 16'(got.f_index));
                    check_field("d_index", 16'(want.d_index), 16'(got.d_index));
                    check_field("ta2_can_change_mode", 16'(want.ta2_can_change_mode),
                                16'(got.ta2_can_change_mode));
                    check_field("ta2_implicit_fd", 16'(want.ta2_implicit_fd),
                                16'(got.ta2_implicit_fd));
                    check_field("ta2_protocol", 16'(want.ta2_protocol),
                                16'(got.ta2_protocol));
                    check_field("extra_guard_time", 16'(want.extra_guard_time),
                                16'(got.extra_guard_time));
                    check_field("waiting_integer", 16'(want.waiting_integer),
                                16'(got.waiting_integer));
                    check_field("protocols_mask", want.protocols_mask, got.protocols_mask);
                end
            end
            if (i_atr.valid && i_atr.ready) begin
                parse_atr_byte(i_atr.data, want);
                parse_results_due.push_back(want);
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= parse_results_due.size();
    end

endmodule
`default_nettype wire

FILE: sim/smart_card_atr_parser_core_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smart_card_atr_parser_core_tb - stimulus and verdict for the ATR parser
// Feeds directed and random Answer-To-Reset byte streams, well-formed and
// broken, under varying source gaps and sink stalls; the checker beside the
// block predicts every result and reports mismatches.
// ----------------------------------------------------------------------------
module smart_card_atr_parser_core_tb;

    localparam int RANDOM_ITEMS   = 1850;
    // cycles without any transfer before the run is abandoned
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_LIMIT    = 4000;
    // tail wait after the drain loop, for anything still in flight
    localparam int DRAIN_TAIL     = 8;

    logic i_clk;
    logic i_rst_n;

    scatr_in_if  atr_if ();
    scatr_out_if res_if ();

    int chk_fails;
    int chk_pending;

    int send_idle_pct;
    int recv_stall_pct;
    int atr_bytes_sent;
    int quiet_cycles;

    smart_card_atr_parser_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_atr   (atr_if),
        .o_res   (res_if)
    );

    smart_card_atr_parser_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_atr        (atr_if),
        .i_res        (res_if),
        .o_fail_count (chk_fails),
        .o_pending    (chk_pending)
    );

    always #2 i_clk = ~i_clk;

    // Sink side: stall at random, at the rate set for the current phase
    always @(posedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: abandon the run if nothing moves on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (atr_if.valid && atr_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[smart_card_atr_parser_core] ERROR");
                $finish;
            end
        end
    end

    // Offer one byte and hold it until the transfer happens. Valid stays high
    // across back-to-back bytes; it only drops for an idle gap.
    task automatic send_item(input logic [7:0] b, input logic err, input logic sof);
        scatr_pkg::t_atr_in item;
        item.rx_byte      = b;
        item.rx_error     = err;
        item.start_of_atr = sof;
        while ($urandom_range(99) < send_idle_pct) begin
            atr_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        atr_if.valid <= 1'b1;
        atr_if.data  <= item;
        do @(posedge i_clk); while (!atr_if.ready);
    endtask

    // Send a byte string as one ATR: start mark on the first byte, an optional
    // reception error at err_pos (-1 for none)
    task automatic send_atr(input logic [7:0] q[$], input int err_pos);
        for (int i = 0; i < q.size(); i++) begin
            send_item(q[i], (i == err_pos), (i == 0));
            atr_bytes_sent++;
        end
    endtask

    task automatic run_directed();
        logic [7:0] q[$];
        logic [7:0] acc;
        // first byte after reset without a start mark still counts as TS;
        // T0 with no levels and no history ends the ATR as good
        send_item(scatr_pkg::TS_DIRECT, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        // after the end, even a failed byte is ignored
        send_item(8'hFF, 1'b1, 1'b0);
        // wrong convention byte
        send_item(8'h3F, 1'b0, 1'b1);
        // every interface byte on levels one and two, T=1 and T=15, one
        // historical byte and a correct TCK
        q = {scatr_pkg::TS_DIRECT, 8'hF1, 8'h96, 8'h00, 8'hFF, 8'hF1,
             8'h90, 8'h55, 8'h0A, 8'h0F, 8'h80};
        acc = 8'h00;
        for (int i = 1; i < q.size(); i++)
            acc ^= q[i];
        q.push_back(acc);
        send_atr(q, -1);
        // reception error on the TS itself, with the start mark
        send_item(scatr_pkg::TS_DIRECT, 1'b1, 1'b1);
        // reception error in the middle of an ATR
        send_item(scatr_pkg::TS_DIRECT, 1'b0, 1'b1);
        send_item(8'h5A, 1'b1, 1'b0);
        atr_bytes_sent += 8;
    endtask

    task automatic run_random_atr();
        logic [7:0] q[$];
        logic [3:0] y;
        logic [3:0] nxt;
        logic [3:0] proto;
        logic [7:0] acc;
        int         hist;
        int         lvl;
        int         lvl_cap;
        int         flavour;
        int         cut;
        int         err_pos;
        bit         zero_protos;
        bit         need_tck;

        // build a well-formed ATR with random content
        hist        = ($urandom_range(7) == 0) ? $urandom_range(8, 15) : $urandom_range(0, 4);
        y           = 4'($urandom);
        zero_protos = ($urandom_range(2) == 0);
        lvl_cap     = ($urandom_range(9) == 0) ? 12 : $urandom_range(1, 3);
        need_tck    = 1'b0;
        lvl         = 0;
        q           = {scatr_pkg::TS_DIRECT, {y, 4'(hist)}};
        while (y != 4'd0) begin
            for (int i = 0; i < 3; i++)
                if (y[i])
                    q.push_back(8'($urandom));
            if (y[3]) begin
                lvl++;
                // long chains keep TD going so that the byte limit can be hit
                if (lvl >= lvl_cap)
                    nxt = 4'd0;
                else if (lvl_cap == 12)
                    nxt = 4'($urandom) | 4'h8;
                else
                    nxt = 4'($urandom);
                proto = zero_protos ? 4'd0 : 4'($urandom);
                if (proto != 4'd0)
                    need_tck = 1'b1;
                q.push_back({nxt, proto});
                y = nxt;
            end else begin
                y = 4'd0;
            end
        end
        repeat (hist) q.push_back(8'($urandom));
        if (need_tck) begin
            acc = 8'h00;
            for (int i = 1; i < q.size(); i++)
                acc ^= q[i];
            q.push_back(acc);
        end

        // break a share of them
        flavour = $urandom_range(99);
        err_pos = -1;
        if (flavour < 10) begin
            q[$urandom_range(1, q.size() - 1)] ^= 8'(1 << $urandom_range(7));
        end else if (flavour < 18) begin
            cut = $urandom_range(1, q.size() - 1);
            while (q.size() > cut)
                void'(q.pop_back());
        end else if (flavour < 24) begin
            q[0] = 8'($urandom);
        end else if (flavour < 32) begin
            err_pos = $urandom_range(0, q.size() - 1);
        end

        send_atr(q, err_pos);

        // junk after the end is ignored; noise may also restart at random
        if (flavour >= 88)
            repeat ($urandom_range(1, 4))
                send_item(8'($urandom), 1'($urandom_range(1)), 1'b0);
        if (flavour >= 95)
            repeat ($urandom_range(1, 3))
                send_item(8'($urandom), ($urandom_range(9) == 0), ($urandom_range(3) == 0));
    endtask

    initial begin
        int stage;
        int waited;
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        atr_if.valid   = 1'b0;
        atr_if.data    = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        atr_bytes_sent = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();

        // random part in four idling phases
        atr_bytes_sent = 0;
        while (atr_bytes_sent < RANDOM_ITEMS) begin
            stage = (atr_bytes_sent * 4) / RANDOM_ITEMS;
            case (stage)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 48;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 48;
                end
                default: begin
                    send_idle_pct  = 17;
                    recv_stall_pct = 17;
                end
            endcase
            run_random_atr();
        end
        atr_if.valid <= 1'b0;

        // let the last expectation register, then wait for the results
        @(posedge i_clk);
        waited = 0;
        while (chk_pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_TAIL) @(posedge i_clk);

        if (chk_fails == 0 && chk_pending == 0) begin
            $display("[smart_card_atr_parser_core] OK");
        end else begin
            $display("[smart_card_atr_parser_core] ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
